@@ rtl/stq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the sorted timer event queue.
// Used by stq_cell and sorted_timer_event_queue; depends on nothing.
package stq_pkg;

  localparam int TIME_W = 63;
  localparam int DEV_W  = 6;

  // Command codes
  localparam logic [1:0] CMD_INS_REL = 2'd0;
  localparam logic [1:0] CMD_INS_ABS = 2'd1;
  localparam logic [1:0] CMD_POLL    = 2'd2;

  // Request word
  typedef struct packed {
    logic [1:0]        command;
    logic [DEV_W-1:0]  device_number;
    logic              event_action;
    logic [TIME_W-1:0] time_value;
    logic [TIME_W-1:0] current_time;
  } request_t;

  // Result word
  typedef struct packed {
    logic [DEV_W-1:0]  expired_device;
    logic              expired_action;
    logic              is_event;
    logic [TIME_W-1:0] next_deadline;
    logic              queue_full;
    logic              last_item;
  } result_t;

  // One stored event
  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [DEV_W-1:0]  device;
    logic              action;
  } entry_t;

  // Chain control, same for every cell
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctl_t;

endpackage

@@ rtl/stq_cell.sv @@
`timescale 1ns / 1ps
// One slot of the sorted event chain: holds an entry and its valid bit,
// takes from its left neighbor or the new entry on insert and from its right neighbor on pop. Uses stq_pkg.
module stq_cell (
  input  logic              clk,
  input  logic              rst,
  input  stq_pkg::cell_ctl_t ctl,
  input  stq_pkg::entry_t   new_entry,
  input  stq_pkg::entry_t   left_entry,
  input  logic              left_valid,
  input  logic              left_after,
  input  stq_pkg::entry_t   right_entry,
  input  logic              right_valid,
  output stq_pkg::entry_t   entry,
  output logic              valid,
  output logic              after
);
  import stq_pkg::*;

  // Slot is empty or holds a later deadline than the new event
  assign after = !valid || (entry.deadline > new_entry.deadline);

  // Advance the payload: shift right on insert, left on pop
  always_ff @(posedge clk) begin
    if (ctl.insert && after) begin
      entry <= left_after ? left_entry : new_entry;
    end else if (ctl.pop) begin
      entry <= right_entry;
    end
  end

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.insert) begin
      valid <= valid | left_valid;
    end else if (ctl.pop) begin
      valid <= right_valid;
    end
  end

endmodule

@@ rtl/sorted_timer_event_queue.sv @@
`timescale 1ns / 1ps
// Sorted timer event queue: a chain of QUEUE_DEPTH cells kept in deadline order.
// Insert: busy while the chain shifts; the acknowledge word strobes after the shift.
// Poll: one expired word per cycle from the head cell, then the final word.
// Unused command: acknowledge strobes the next cycle. Results cannot be stalled.
// Synchronous reset empties the queue and returns to idle. Uses stq_pkg and stq_cell.
module sorted_timer_event_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  stq_pkg::request_t request,
  output logic              busy,
  output logic              result_strobe,
  output stq_pkg::result_t  result
);
  import stq_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_POLL   = 2'd2;

  logic [1:0]        state;
  entry_t            new_entry;
  logic [TIME_W-1:0] now;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] deadline_calc;
  logic              accept;
  logic              full;
  logic              head_expired;
  cell_ctl_t         ctl;
  result_t           result_next;

  entry_t cell_entry  [QUEUE_DEPTH];
  logic   cell_valid  [QUEUE_DEPTH];
  logic   cell_after  [QUEUE_DEPTH];
  entry_t left_entry  [QUEUE_DEPTH];
  logic   left_valid  [QUEUE_DEPTH];
  logic   left_after  [QUEUE_DEPTH];
  entry_t right_entry [QUEUE_DEPTH];
  logic   right_valid [QUEUE_DEPTH];

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Saturating relative deadline
  assign sum = {1'b0, request.time_value} + {1'b0, request.current_time};
  always_comb begin
    if (request.command == CMD_INS_REL) begin
      deadline_calc = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    end else begin
      deadline_calc = request.time_value;
    end
  end

  assign full         = cell_valid[QUEUE_DEPTH-1];
  assign head_expired = cell_valid[0] && (cell_entry[0].deadline < now);

  // Chain control
  always_comb begin
    ctl.insert = (state == ST_INSERT) && !full;
    ctl.pop    = (state == ST_POLL) && head_expired;
  end

  // Wire up neighbors
  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign left_entry[i] = new_entry;
        assign left_valid[i] = 1'b1;
        assign left_after[i] = 1'b0;
      end else begin : g_mid
        assign left_entry[i] = cell_entry[i-1];
        assign left_valid[i] = cell_valid[i-1];
        assign left_after[i] = cell_after[i-1];
      end
      if (i == QUEUE_DEPTH-1) begin : g_last
        assign right_entry[i] = cell_entry[i];
        assign right_valid[i] = 1'b0;
      end else begin : g_inner
        assign right_entry[i] = cell_entry[i+1];
        assign right_valid[i] = cell_valid[i+1];
      end

      stq_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .new_entry   (new_entry),
        .left_entry  (left_entry[i]),
        .left_valid  (left_valid[i]),
        .left_after  (left_after[i]),
        .right_entry (right_entry[i]),
        .right_valid (right_valid[i]),
        .entry       (cell_entry[i]),
        .valid       (cell_valid[i]),
        .after       (cell_after[i])
      );
    end
  endgenerate

  // Hold the accepted command's operands
  always_ff @(posedge clk) begin
    if (accept) begin
      new_entry.deadline <= deadline_calc;
      new_entry.device   <= request.device_number;
      new_entry.action   <= request.event_action;
      now                <= request.current_time;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (request.command)
              CMD_INS_REL, CMD_INS_ABS: state <= ST_INSERT;
              CMD_POLL:                 state <= ST_POLL;
              default:                  state <= ST_IDLE;
            endcase
          end
        end
        ST_INSERT: state <= ST_IDLE;
        ST_POLL: begin
          if (!head_expired) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (state == ST_INSERT) || (state == ST_POLL) ||
                       (accept && (request.command != CMD_INS_REL) &&
                        (request.command != CMD_INS_ABS) &&
                        (request.command != CMD_POLL));
    end
  end

  // Build the result word
  always_comb begin
    result_next = '0;
    case (state)
      ST_INSERT: begin
        result_next.queue_full = full;
        result_next.last_item  = 1'b1;
      end
      ST_POLL: begin
        if (head_expired) begin
          result_next.expired_device = cell_entry[0].device;
          result_next.expired_action = cell_entry[0].action;
          result_next.is_event       = 1'b1;
        end else begin
          result_next.next_deadline = cell_valid[0] ? cell_entry[0].deadline : '0;
          result_next.last_item     = 1'b1;
        end
      end
      default: begin
        result_next.last_item = 1'b1;
      end
    endcase
  end

  // Register the result word
  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sorted_timer_event_queue: directed and random command words,
// a shadow deadline-ordered queue that predicts every result word. Depends on stq_pkg and the RTL.
module tb;
  import stq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int RANDOM_WORDS = 330;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct {
    request_t    req;
    int unsigned idle_pct;
  } pending_word_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     result_strobe;
  result_t  result;

  pending_word_t request_backlog[$];
  result_t       expected_words[$];
  entry_t        timer_events[$];

  int unsigned words_total = 0;
  int unsigned words_accepted = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned insert_count = 0;
  int unsigned dropped_count = 0;
  int unsigned saturated_count = 0;
  int unsigned poll_count = 0;
  int unsigned expired_count = 0;
  pending_word_t next_word;

  sorted_timer_event_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .result_strobe(result_strobe),
    .result(result)
  );

  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [TIME_W-1:0] random_time();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[TIME_W-1:0];
  endfunction

  function automatic request_t make_word(logic [1:0] cmd, logic [DEV_W-1:0] dev, logic act,
                                         logic [TIME_W-1:0] tv, logic [TIME_W-1:0] now);
    request_t w;
    w.command = cmd;
    w.device_number = dev;
    w.event_action = act;
    w.time_value = tv;
    w.current_time = now;
    return w;
  endfunction

  task automatic queue_word(input request_t req, input int unsigned idle_pct);
    pending_word_t p;
    p.req = req;
    p.idle_pct = idle_pct;
    request_backlog.push_back(p);
    words_total++;
  endtask

  // Update the shadow event queue and queue the result words this command causes
  task automatic predict_queue_response(input request_t req);
    logic [63:0] sum;
    entry_t      ev;
    result_t     word;
    int          pos;
    word = '0;
    case (req.command)
      CMD_INS_REL, CMD_INS_ABS: begin
        insert_count++;
        ev.deadline = req.time_value;
        if (req.command == CMD_INS_REL) begin
          sum = {1'b0, req.time_value} + {1'b0, req.current_time};
          ev.deadline = sum[63] ? TIME_MAX : sum[TIME_W-1:0];
          if (sum[63]) saturated_count++;
        end
        ev.device = req.device_number;
        ev.action = req.event_action;
        word.last_item = 1'b1;
        if (timer_events.size() >= QUEUE_DEPTH) begin
          word.queue_full = 1'b1;
          dropped_count++;
        end else begin
          // Go in behind every entry with an equal or earlier deadline
          pos = timer_events.size();
          for (int i = 0; i < timer_events.size(); i++) begin
            if (timer_events[i].deadline > ev.deadline) begin
              pos = i;
              break;
            end
          end
          timer_events.insert(pos, ev);
        end
        expected_words.push_back(word);
      end
      CMD_POLL: begin
        poll_count++;
        while (timer_events.size() > 0 && timer_events[0].deadline < req.current_time) begin
          word = '0;
          word.expired_device = timer_events[0].device;
          word.expired_action = timer_events[0].action;
          word.is_event = 1'b1;
          expected_words.push_back(word);
          void'(timer_events.pop_front());
          expired_count++;
        end
        word = '0;
        word.last_item = 1'b1;
        if (timer_events.size() > 0) word.next_deadline = timer_events[0].deadline;
        expected_words.push_back(word);
      end
      default: begin
        word.last_item = 1'b1;
        expected_words.push_back(word);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] exp_val,
                             input logic [TIME_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Driver: hold the word until accepted, then offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_queue_response(request);
        words_accepted++;
      end
      if (!start || !busy) begin
        if (request_backlog.size() != 0 &&
            $urandom_range(99) >= request_backlog[0].idle_pct) begin
          next_word = request_backlog.pop_front();
          start <= 1'b1;
          request <= next_word.req;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every strobed word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: device %0d action %0d event %0d deadline %0d",
               result.expired_device, result.expired_action, result.is_event,
               result.next_deadline);
        error_count++;
      end else begin
        check_field("expired_device", TIME_W'(expected_words[0].expired_device),
                    TIME_W'(result.expired_device));
        check_field("expired_action", TIME_W'(expected_words[0].expired_action),
                    TIME_W'(result.expired_action));
        check_field("is_event", TIME_W'(expected_words[0].is_event),
                    TIME_W'(result.is_event));
        check_field("next_deadline", expected_words[0].next_deadline, result.next_deadline);
        check_field("queue_full", TIME_W'(expected_words[0].queue_full),
                    TIME_W'(result.queue_full));
        check_field("last_item", TIME_W'(expected_words[0].last_item),
                    TIME_W'(result.last_item));
        void'(expected_words.pop_front());
      end
    end
  end

  // Stimulus, end of run and verdict
  initial begin
    logic [TIME_W-1:0] sim_now;
    logic [TIME_W-1:0] now_val;
    logic [TIME_W-1:0] tv;
    logic [1:0]        cmd;
    int unsigned       pick;
    int unsigned       idle_pct;
    bit                wide;

    // Directed: empty queue, unused command, zero and saturated deadlines, ties
    queue_word(make_word(CMD_POLL, 6'd0, 1'b0, '0, '0), 0);
    queue_word(make_word(CMD_UNUSED, 6'd63, 1'b1, TIME_MAX, TIME_MAX), 0);
    queue_word(make_word(CMD_INS_ABS, 6'd0, 1'b0, '0, TIME_MAX), 0);
    queue_word(make_word(CMD_POLL, 6'd0, 1'b0, '0, '0), 0);
    queue_word(make_word(CMD_INS_REL, 6'd63, 1'b1, TIME_MAX, TIME_MAX), 0);
    queue_word(make_word(CMD_INS_REL, 6'd5, 1'b0, 63'd5, 63'd10), 0);
    queue_word(make_word(CMD_INS_ABS, 6'd1, 1'b1, 63'd15, 63'd0), 0);
    // Fill to capacity, then overflow with both insert kinds
    for (int i = 0; i < QUEUE_DEPTH - 4; i++) begin
      queue_word(make_word(CMD_INS_ABS, 6'($urandom_range(63)), 1'($urandom_range(1)),
                           63'($urandom_range(30)), 63'd0), 0);
    end
    queue_word(make_word(CMD_INS_ABS, 6'd7, 1'b1, 63'd1, 63'd0), 0);
    queue_word(make_word(CMD_INS_REL, 6'd8, 1'b0, 63'd1, 63'd0), 0);
    // Partial expiry, full drain short of the saturated entry, then an empty-handed poll
    queue_word(make_word(CMD_POLL, 6'd0, 1'b0, '0, 63'd16), 0);
    queue_word(make_word(CMD_POLL, 6'd0, 1'b0, '0, TIME_MAX), 0);
    queue_word(make_word(CMD_POLL, 6'd0, 1'b0, '0, TIME_MAX), 0);

    // Random: advancing clock, deadlines near it, occasional full-width values
    sim_now = 63'd1000;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      case (i * 4 / RANDOM_WORDS)
        1: idle_pct = 59;
        3: idle_pct = 21;
        default: idle_pct = 0;
      endcase
      sim_now = sim_now + 63'($urandom_range(40));
      wide = ($urandom_range(9) == 0);
      now_val = wide ? random_time() : sim_now;
      pick = $urandom_range(99);
      if (pick < 38) begin
        cmd = CMD_INS_REL;
        tv = wide ? random_time() : 63'($urandom_range(300));
      end else if (pick < 62) begin
        cmd = CMD_INS_ABS;
        tv = wide ? random_time() : sim_now + 63'($urandom_range(300)) - 63'd50;
      end else if (pick < 96) begin
        cmd = CMD_POLL;
        tv = random_time();
      end else begin
        cmd = CMD_UNUSED;
        tv = random_time();
      end
      queue_word(make_word(cmd, 6'($urandom_range(63)), 1'($urandom_range(1)), tv, now_val),
                 idle_pct);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait for every word to be taken and answered, then let the block settle
    @(negedge clk);
    while (words_accepted != words_total || expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d command words: %0d inserts (%0d dropped when full, %0d saturated)",
             words_accepted, insert_count, dropped_count, saturated_count);
    $display("and %0d polls that expired %0d events.", poll_count, expired_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/stq_pkg.sv
rtl/stq_cell.sv
rtl/sorted_timer_event_queue.sv
bench/tb.sv
